@@ sv/fcs_pkg.sv @@
// Package for the floppy controller sequencer: geometry constants, codes,
// and the structs passed between the sequencer modules.
// No dependencies.
package fcs_pkg;

    // Disk geometry.
    localparam int SECTORS_PER_TRACK = 18;
    localparam int HEAD_COUNT        = 2;
    localparam int CYLINDER_COUNT    = 80;
    localparam int PER_CYL           = SECTORS_PER_TRACK * HEAD_COUNT;
    localparam int TOTAL_BLOCKS      = PER_CYL * CYLINDER_COUNT;

    // Field widths fixed by the interface.
    localparam int BLK_W   = 12;
    localparam int CYL_W   = 7;
    localparam int SEC_W   = 5;
    localparam int TICK_W  = 16;
    localparam int LIMIT_W = 3;
    localparam int RETRY_W = 4;
    localparam int CIDX_W  = 3;

    // Division of a block number by PER_CYL as a multiply by a rounded-up
    // reciprocal; exact over the whole BLK_W range.
    localparam int DIV_SHIFT = BLK_W + $clog2(PER_CYL);
    localparam int DIV_MULT  = ((1 << DIV_SHIFT) + PER_CYL - 1) / PER_CYL;
    localparam int MULT_W    = $clog2(DIV_MULT + 1);
    localparam int PROD_W    = BLK_W + MULT_W;
    localparam int REM_W     = $clog2(PER_CYL);

    // ST0 status checks.
    localparam logic [7:0] ST0_SEEK_MASK = 8'hF8;
    localparam logic [7:0] ST0_SEEK_PASS = 8'h20;
    localparam logic [7:0] ST0_IO_MASK   = 8'hD8;

    // Configuration reset values.
    localparam logic [TICK_W-1:0]  RST_SPINUP   = 16'd250;
    localparam logic [TICK_W-1:0]  RST_RESET    = 16'd500;
    localparam logic [TICK_W-1:0]  RST_RECAL    = 16'd5000;
    localparam logic [TICK_W-1:0]  RST_SEEK     = 16'd4000;
    localparam logic [TICK_W-1:0]  RST_TRANSFER = 16'd2000;
    localparam logic [TICK_W-1:0]  RST_IDLE_OFF = 16'd5000;
    localparam logic [LIMIT_W-1:0] RST_LIMIT    = 3'd3;

    // Configuration register indexes.
    localparam logic [CIDX_W-1:0] CFG_SPINUP   = 3'd0;
    localparam logic [CIDX_W-1:0] CFG_RESET    = 3'd1;
    localparam logic [CIDX_W-1:0] CFG_RECAL    = 3'd2;
    localparam logic [CIDX_W-1:0] CFG_SEEK     = 3'd3;
    localparam logic [CIDX_W-1:0] CFG_TRANSFER = 3'd4;
    localparam logic [CIDX_W-1:0] CFG_IDLE_OFF = 3'd5;
    localparam logic [CIDX_W-1:0] CFG_LIMIT    = 3'd6;

    typedef enum logic [1:0] {
        OP_REQUEST = 2'd0,
        OP_IRQ     = 2'd1,
        OP_TICK    = 2'd2,
        OP_CLOSE   = 2'd3
    } t_op;

    typedef enum logic [2:0] {
        ACT_NONE      = 3'd0,
        ACT_MOTOR_OFF = 3'd1,
        ACT_MOTOR_ON  = 3'd2,
        ACT_RESET     = 3'd3,
        ACT_RECAL     = 3'd4,
        ACT_SEEK      = 3'd5,
        ACT_READ      = 3'd6,
        ACT_WRITE     = 3'd7
    } t_action;

    typedef enum logic [6:0] {
        PH_OFF   = 7'b0000001,
        PH_ON    = 7'b0000010,
        PH_RESET = 7'b0000100,
        PH_RECAL = 7'b0001000,
        PH_SEEK  = 7'b0010000,
        PH_IO    = 7'b0100000,
        PH_READY = 7'b1000000
    } t_phase;

    typedef struct packed {
        t_op               operation;
        logic              is_write;
        logic [BLK_W-1:0]  block_number;
        logic [SEC_W-1:0]  sector_count;
        logic [7:0]        status_byte;
    } t_cmd;

    typedef struct packed {
        t_action           action;
        logic              head;
        logic [CYL_W-1:0]  cylinder;
        logic [SEC_W-1:0]  sector;
        logic [SEC_W-1:0]  transfer_count;
        logic              done_res;
        logic              failed;
    } t_res;

    typedef struct packed {
        logic              head;
        logic [CYL_W-1:0]  cylinder;
        logic [SEC_W-1:0]  sector;
    } t_geo;

    typedef struct packed {
        logic [TICK_W-1:0]  spinup_ticks;
        logic [TICK_W-1:0]  reset_ticks;
        logic [TICK_W-1:0]  recal_ticks;
        logic [TICK_W-1:0]  seek_ticks;
        logic [TICK_W-1:0]  transfer_ticks;
        logic [TICK_W-1:0]  idle_off_ticks;
        logic [LIMIT_W-1:0] retry_limit;
    } t_cfg;

endpackage

@@ sv/fcs_if.sv @@
// Valid/ready channel interfaces of the floppy controller sequencer:
// command input, result output and configuration write.
// Depends on fcs_pkg for field widths.
interface fcs_in_if;
    import fcs_pkg::*;

    logic                valid;
    logic                ready;
    logic [1:0]          operation;
    logic                is_write;
    logic [BLK_W-1:0]    block_number;
    logic [SEC_W-1:0]    sector_count;
    logic [7:0]          status_byte;

    modport source (
        output valid, operation, is_write, block_number, sector_count, status_byte,
        input  ready
    );
    modport sink (
        input  valid, operation, is_write, block_number, sector_count, status_byte,
        output ready
    );
endinterface

interface fcs_out_if;
    import fcs_pkg::*;

    logic                valid;
    logic                ready;
    logic [2:0]          action;
    logic                head;
    logic [CYL_W-1:0]    cylinder;
    logic [SEC_W-1:0]    sector;
    logic [SEC_W-1:0]    transfer_count;
    logic                done_res;
    logic                failed;

    modport source (
        output valid, action, head, cylinder, sector, transfer_count, done_res, failed,
        input  ready
    );
    modport sink (
        input  valid, action, head, cylinder, sector, transfer_count, done_res, failed,
        output ready
    );
endinterface

interface fcs_cfg_if;
    import fcs_pkg::*;

    logic                valid;
    logic                ready;
    logic [CIDX_W-1:0]   index;
    logic [TICK_W-1:0]   data;

    modport source (
        output valid, index, data,
        input  ready
    );
    modport sink (
        input  valid, index, data,
        output ready
    );
endinterface

@@ sv/fcs_cfg_regs.sv @@
// Configuration register file of the floppy controller sequencer.
// Depends on fcs_pkg and the fcs_cfg_if interface.
module fcs_cfg_regs (
    input  logic             i_clk,
    input  logic             i_rst_n,
    fcs_cfg_if.sink          i_cfg,
    output fcs_pkg::t_cfg    o_cfg
);
    import fcs_pkg::*;

    t_cfg r_cfg;

    // Writes are always taken; an index beyond the list is dropped.
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.spinup_ticks   <= RST_SPINUP;
            r_cfg.reset_ticks    <= RST_RESET;
            r_cfg.recal_ticks    <= RST_RECAL;
            r_cfg.seek_ticks     <= RST_SEEK;
            r_cfg.transfer_ticks <= RST_TRANSFER;
            r_cfg.idle_off_ticks <= RST_IDLE_OFF;
            r_cfg.retry_limit    <= RST_LIMIT;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                CFG_SPINUP:   r_cfg.spinup_ticks   <= i_cfg.data;
                CFG_RESET:    r_cfg.reset_ticks    <= i_cfg.data;
                CFG_RECAL:    r_cfg.recal_ticks    <= i_cfg.data;
                CFG_SEEK:     r_cfg.seek_ticks     <= i_cfg.data;
                CFG_TRANSFER: r_cfg.transfer_ticks <= i_cfg.data;
                CFG_IDLE_OFF: r_cfg.idle_off_ticks <= i_cfg.data;
                CFG_LIMIT:    r_cfg.retry_limit    <= i_cfg.data[LIMIT_W-1:0];
                default: begin
                end
            endcase
        end
    end

    assign o_cfg = r_cfg;
endmodule

@@ sv/fcs_geometry.sv @@
// Splits a logical block number into head, cylinder and one-based sector.
// Depends on fcs_pkg; the division is a reciprocal multiply.
module fcs_geometry (
    input  logic [fcs_pkg::BLK_W-1:0] i_block,
    output fcs_pkg::t_geo              o_geo
);
    import fcs_pkg::*;

    logic [PROD_W-1:0]          w_prod;
    logic [PROD_W-DIV_SHIFT-1:0] w_quot;
    logic [BLK_W-1:0]           w_quot_blk;
    logic [BLK_W-1:0]           w_rem_full;
    logic [REM_W-1:0]           w_rem;
    logic                       w_upper;
    logic [REM_W-1:0]           w_sec_rem;

    // Cylinder is the block divided by the sectors per cylinder.
    assign w_prod     = PROD_W'(i_block) * PROD_W'(DIV_MULT);
    assign w_quot     = w_prod[PROD_W-1:DIV_SHIFT];
    assign w_quot_blk = BLK_W'(w_quot);

    // Remainder within the cylinder picks the head and the sector.
    assign w_rem_full = i_block - BLK_W'(w_quot_blk * BLK_W'(PER_CYL));
    assign w_rem      = w_rem_full[REM_W-1:0];
    assign w_upper    = (HEAD_COUNT > 1) && (w_rem >= REM_W'(SECTORS_PER_TRACK));
    assign w_sec_rem  = w_upper ? (w_rem - REM_W'(SECTORS_PER_TRACK)) : w_rem;

    assign o_geo.head     = w_upper;
    assign o_geo.cylinder = CYL_W'(w_quot_blk);
    assign o_geo.sector   = SEC_W'(w_sec_rem) + SEC_W'(1);
endmodule

@@ sv/fcs_sequencer.sv @@
// Phase state machine, timeout timer and retry counter of the floppy
// controller sequencer. Depends on fcs_pkg.
module fcs_sequencer (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_fire,
    input  fcs_pkg::t_cmd    i_cmd,
    input  fcs_pkg::t_geo    i_geo,
    input  fcs_pkg::t_cfg    i_cfg,
    output logic             o_has_res,
    output fcs_pkg::t_res    o_res
);
    import fcs_pkg::*;

    t_phase              r_phase, n_phase;
    logic                r_active, n_active;
    logic                r_write, n_write;
    t_geo                r_geo, n_geo;
    logic [SEC_W-1:0]    r_count, n_count;
    logic [RETRY_W-1:0]  r_retry, n_retry;
    logic [TICK_W-1:0]   r_left, n_left;
    logic                r_running, n_running;

    logic                w_invalid;
    logic                w_seek_pass;
    logic                w_io_pass;
    logic [RETRY_W-1:0]  w_retry_inc;
    logic                w_retry_ok;
    logic                do_retry, do_reset, do_fail, do_seek;
    logic                has_res, res_geo, res_xfer, dn, fl;
    t_action             act;

    // Request screening and status byte checks.
    assign w_invalid   = (32'(i_cmd.block_number) >= 32'(TOTAL_BLOCKS))
                      || (i_cmd.sector_count == '0)
                      || (32'(i_cmd.sector_count) > 32'(SECTORS_PER_TRACK));
    assign w_seek_pass = (i_cmd.status_byte & ST0_SEEK_MASK) == ST0_SEEK_PASS;
    assign w_io_pass   = (i_cmd.status_byte & ST0_IO_MASK) == 8'h00;
    assign w_retry_inc = r_retry + RETRY_W'(1);
    assign w_retry_ok  = w_retry_inc <= RETRY_W'(i_cfg.retry_limit);

    // Next state and result for the item in the input register.
    always_comb begin
        n_phase   = r_phase;
        n_active  = r_active;
        n_write   = r_write;
        n_geo     = r_geo;
        n_count   = r_count;
        n_retry   = r_retry;
        n_left    = r_left;
        n_running = r_running;
        do_retry  = 1'b0;
        do_reset  = 1'b0;
        do_fail   = 1'b0;
        do_seek   = 1'b0;
        has_res   = 1'b0;
        res_geo   = 1'b0;
        res_xfer  = 1'b0;
        dn        = 1'b0;
        fl        = 1'b0;
        act       = ACT_NONE;

        case (i_cmd.operation)
            OP_REQUEST: begin
                if (w_invalid) begin
                    has_res = 1'b1;
                    dn      = 1'b1;
                    fl      = 1'b1;
                end else begin
                    n_write  = i_cmd.is_write;
                    n_geo    = i_geo;
                    n_count  = i_cmd.sector_count;
                    n_retry  = '0;
                    n_active = 1'b1;
                    if (r_phase == PH_OFF) begin
                        n_phase   = PH_ON;
                        n_left    = i_cfg.spinup_ticks;
                        n_running = 1'b1;
                        has_res   = 1'b1;
                        act       = ACT_MOTOR_ON;
                    end else begin
                        do_seek = 1'b1;
                    end
                end
            end
            OP_IRQ: begin
                if (r_active) begin
                    case (r_phase)
                        PH_RESET: begin
                            n_phase   = PH_RECAL;
                            n_left    = i_cfg.recal_ticks;
                            n_running = 1'b1;
                            has_res   = 1'b1;
                            act       = ACT_RECAL;
                        end
                        PH_RECAL: begin
                            do_seek = w_seek_pass;
                            do_fail = !w_seek_pass;
                        end
                        PH_SEEK: begin
                            if (w_seek_pass) begin
                                n_phase   = PH_IO;
                                n_left    = i_cfg.transfer_ticks;
                                n_running = 1'b1;
                                has_res   = 1'b1;
                                res_geo   = 1'b1;
                                res_xfer  = 1'b1;
                                act       = r_write ? ACT_WRITE : ACT_READ;
                            end else begin
                                do_retry = 1'b1;
                            end
                        end
                        PH_IO: begin
                            if (w_io_pass) begin
                                n_phase   = PH_READY;
                                n_left    = i_cfg.idle_off_ticks;
                                n_running = 1'b1;
                                n_active  = 1'b0;
                                has_res   = 1'b1;
                                dn        = 1'b1;
                            end else begin
                                do_retry = 1'b1;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            OP_TICK: begin
                if (r_running) begin
                    if (r_left > TICK_W'(1)) begin
                        n_left = r_left - TICK_W'(1);
                    end else begin
                        n_left    = '0;
                        n_running = 1'b0;
                        if (r_phase == PH_ON) begin
                            do_reset = 1'b1;
                        end else if (r_phase inside {PH_RESET, PH_RECAL}) begin
                            do_fail = 1'b1;
                        end else if (r_phase inside {PH_SEEK, PH_IO}) begin
                            do_retry = 1'b1;
                        end else begin
                            // Idle timeout in ready: stop the motor quietly.
                            n_phase  = PH_OFF;
                            n_active = 1'b0;
                            has_res  = 1'b1;
                            act      = ACT_MOTOR_OFF;
                        end
                    end
                end
            end
            default: begin
                // Close: stop everything, failing a request still open.
                n_phase   = PH_OFF;
                n_running = 1'b0;
                n_left    = '0;
                n_active  = 1'b0;
                has_res   = 1'b1;
                act       = ACT_MOTOR_OFF;
                dn        = r_active;
                fl        = r_active;
            end
        endcase

        // Seek or transfer failure: retry through reset until the limit.
        if (do_retry) begin
            n_retry  = w_retry_inc;
            do_reset = w_retry_ok;
            do_fail  = !w_retry_ok;
        end

        if (do_reset) begin
            n_phase   = PH_RESET;
            n_left    = i_cfg.reset_ticks;
            n_running = 1'b1;
            has_res   = 1'b1;
            act       = ACT_RESET;
        end

        if (do_fail) begin
            n_phase   = PH_OFF;
            n_running = 1'b0;
            n_left    = '0;
            n_active  = 1'b0;
            has_res   = 1'b1;
            act       = ACT_MOTOR_OFF;
            dn        = 1'b1;
            fl        = 1'b1;
        end

        if (do_seek) begin
            n_phase   = PH_SEEK;
            n_left    = i_cfg.seek_ticks;
            n_running = 1'b1;
            has_res   = 1'b1;
            res_geo   = 1'b1;
            act       = ACT_SEEK;
        end
    end

    // Result fields; geometry and count only where the command uses them.
    always_comb begin
        o_res                = '0;
        o_res.action         = act;
        o_res.done_res       = dn;
        o_res.failed         = fl;
        if (res_geo) begin
            o_res.head     = n_geo.head;
            o_res.cylinder = n_geo.cylinder;
        end
        if (res_xfer) begin
            o_res.sector         = n_geo.sector;
            o_res.transfer_count = n_count;
        end
    end

    assign o_has_res = has_res;

    // State registers advance once per processed item.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_OFF;
            r_active  <= 1'b0;
            r_write   <= 1'b0;
            r_geo     <= '{head: 1'b0, cylinder: '0, sector: SEC_W'(1)};
            r_count   <= SEC_W'(1);
            r_retry   <= '0;
            r_left    <= '0;
            r_running <= 1'b0;
        end else if (i_fire) begin
            r_phase   <= n_phase;
            r_active  <= n_active;
            r_write   <= n_write;
            r_geo     <= n_geo;
            r_count   <= n_count;
            r_retry   <= n_retry;
            r_left    <= n_left;
            r_running <= n_running;
        end
    end
endmodule

@@ sv/floppy_controller_sequencer_unit.sv @@
// Top level of the floppy controller sequencer: input register, sequencer,
// geometry split, configuration registers and result register.
// Depends on fcs_pkg, fcs_if, fcs_cfg_regs, fcs_geometry and fcs_sequencer.
//
// Usage:
//   i_req carries one beat per event: a request, a controller interrupt
//   with ST0, a timer tick, or a close. o_res carries one beat for every
//   event that issues a drive command or ends a request; events that only
//   count down the timer or are ignored give no beat. i_cfg writes the
//   timeout and retry registers by index and is always ready; write it
//   only while no event is in flight.
//   A beat taken at one clock edge sits in the input register and is
//   resolved once the result register has room, then shown on o_res.
//   One beat per cycle is taken while o_res is not stalled; the rate
//   is set by the single pass from input register to result register.
//   When o_res is stalled the input register still takes one more
//   beat, then i_req.ready drops until the result beat is taken.
//   Synchronous reset puts the motor phase to off, clears any request,
//   empties both registers and loads the register defaults.
module floppy_controller_sequencer_unit (
    input  logic     i_clk,
    input  logic     i_rst_n,
    fcs_in_if.sink   i_req,
    fcs_out_if.source o_res,
    fcs_cfg_if.sink  i_cfg
);
    import fcs_pkg::*;

    logic    r_in_valid;
    t_cmd    r_cmd;
    logic    r_out_valid;
    t_res    r_res;
    logic    w_advance;
    logic    w_has_res;
    t_res    w_res;
    t_geo    w_geo;
    t_cfg    w_cfg;

    fcs_cfg_regs u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (i_cfg),
        .o_cfg   (w_cfg)
    );

    fcs_geometry u_geo (
        .i_block (r_cmd.block_number),
        .o_geo   (w_geo)
    );

    fcs_sequencer u_seq (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_fire    (w_advance),
        .i_cmd     (r_cmd),
        .i_geo     (w_geo),
        .i_cfg     (w_cfg),
        .o_has_res (w_has_res),
        .o_res     (w_res)
    );

    // The held beat is resolved once the result register has room.
    assign w_advance   = r_in_valid && (!r_out_valid || o_res.ready);
    assign i_req.ready = !r_in_valid || w_advance;

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_req.valid && i_req.ready) begin
            r_in_valid <= 1'b1;
        end else if (w_advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.valid && i_req.ready) begin
            r_cmd.operation    <= t_op'(i_req.operation);
            r_cmd.is_write     <= i_req.is_write;
            r_cmd.block_number <= i_req.block_number;
            r_cmd.sector_count <= i_req.sector_count;
            r_cmd.status_byte  <= i_req.status_byte;
        end
    end

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_advance) begin
            r_out_valid <= w_has_res;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_advance && w_has_res) begin
            r_res <= w_res;
        end
    end

    assign o_res.valid          = r_out_valid;
    assign o_res.action         = r_res.action;
    assign o_res.head           = r_res.head;
    assign o_res.cylinder       = r_res.cylinder;
    assign o_res.sector         = r_res.sector;
    assign o_res.transfer_count = r_res.transfer_count;
    assign o_res.done_res       = r_res.done_res;
    assign o_res.failed         = r_res.failed;
endmodule

@@ sv/fcs_checker.sv @@
// Port-level checks for the floppy controller sequencer, bound to the top.
// Depends on fcs_pkg and floppy_controller_sequencer_unit.
module fcs_checker (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_out_valid,
    input  logic                      i_out_ready,
    input  logic [2:0]                i_action,
    input  logic                      i_head,
    input  logic [fcs_pkg::CYL_W-1:0] i_cylinder,
    input  logic [fcs_pkg::SEC_W-1:0] i_sector,
    input  logic [fcs_pkg::SEC_W-1:0] i_transfer_count,
    input  logic                      i_done_res,
    input  logic                      i_failed
);
    import fcs_pkg::*;

    // Reset empties the result register.
    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result beat shown right after reset");

    // A stalled result beat stays offered.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("result beat dropped while stalled");

    // An error is only ever reported together with completion.
    a_fail_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_failed |-> i_done_res)
        else $error("failed without done");

    // Head and cylinder are only given with seek or transfer commands.
    a_geo_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_action != ACT_SEEK && i_action != ACT_READ
            && i_action != ACT_WRITE |-> !i_head && i_cylinder == '0)
        else $error("geometry on a non-positioning command");

    // Transfers always carry a sector and a nonzero count.
    a_xfer_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && (i_action == ACT_READ || i_action == ACT_WRITE)
            |-> i_sector != '0 && i_transfer_count != '0)
        else $error("transfer without sector or count");
endmodule

bind floppy_controller_sequencer_unit fcs_checker u_fcs_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .i_out_valid      (o_res.valid),
    .i_out_ready      (o_res.ready),
    .i_action         (o_res.action),
    .i_head           (o_res.head),
    .i_cylinder       (o_res.cylinder),
    .i_sector         (o_res.sector),
    .i_transfer_count (o_res.transfer_count),
    .i_done_res       (o_res.done_res),
    .i_failed         (o_res.failed)
);
